// ----- sv/ptlc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptlc_pkg: shared types and constants of the priority traffic light controller
// Holds the payload structs, the one-hot mode encoding, the lamp patterns and
// the register map used by the sequencer step logic and the top level.
// ----------------------------------------------------------------------------
package ptlc_pkg;

    localparam int TICK_W      = 10;
    localparam int LAMP_W      = 5;
    localparam int MODE_W      = 3;
    localparam int PEND_W      = 3;
    localparam int CFG_INDEX_W = 3;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_PHASE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EMERGENCY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WARN         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALK         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK        = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0] RST_NORMAL_PHASE = 10'd50;
    localparam logic [TICK_W-1:0] RST_EMERGENCY    = 10'd100;
    localparam logic [TICK_W-1:0] RST_WARN         = 10'd50;
    localparam logic [TICK_W-1:0] RST_WALK         = 10'd100;
    localparam logic [TICK_W-1:0] RST_BLINK        = 10'd5;

    // Mode codes on the result channel
    localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EMERG  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WARN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WALK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAINT  = 3'd4;

    // Pending request bit positions
    localparam int PEND_E = 0;
    localparam int PEND_P = 1;
    localparam int PEND_M = 2;

    // Lamp patterns: bit0 PD5, bit1 PD6, bit2 PD7, bit3 PB0, bit4 PB1
    localparam logic [LAMP_W-1:0] LAMP_PD6 = 5'h02;
    localparam logic [LAMP_W-1:0] PAT_A    = 5'h11;
    localparam logic [LAMP_W-1:0] PAT_B    = 5'h0C;

    typedef enum logic [4:0] {
        ST_NORMAL = 5'b00001,
        ST_EMERG  = 5'b00010,
        ST_WARN   = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_MAINT  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic emergency_req;
        logic pedestrian_req;
        logic maintenance_req;
        logic tick;
    } item_t;

    typedef struct packed {
        logic [LAMP_W-1:0] lamps;
        logic [MODE_W-1:0] mode;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] normal_phase_ticks;
        logic [TICK_W-1:0] emergency_ticks;
        logic [TICK_W-1:0] warn_ticks;
        logic [TICK_W-1:0] walk_ticks;
        logic [TICK_W-1:0] blink_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic              phase;
        logic [TICK_W-1:0] count;
        logic [PEND_W-1:0] pend;
        logic [LAMP_W-1:0] lamp;
    } state_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            ST_EMERG: code = MODE_EMERG;
            ST_WARN:  code = MODE_WARN;
            ST_WALK:  code = MODE_WALK;
            ST_MAINT: code = MODE_MAINT;
            default:  code = MODE_NORMAL;
        endcase
        return code;
    endfunction

endpackage

// ----- sv/ptlc_step.sv -----
// ----------------------------------------------------------------------------
// ptlc_step: next-state logic of the traffic light sequencer
// Latches request edges, advances the tick counter of the current mode and
// resolves mode changes by priority, all for one transaction.
// ----------------------------------------------------------------------------
module ptlc_step
    import ptlc_pkg::*;
(
    input  state_t  state,
    input  cfg_t    cfg,
    input  item_t   item,
    output state_t  state_next,
    output result_t result
);

    // Serve pending requests; clears the counter.
    function automatic state_t dispatch(input state_t s);
        state_t d;
        d       = s;
        d.count = '0;
        if (s.pend[PEND_E]) begin
            d.mode = ST_EMERG;
            d.lamp = PAT_B;
        end
        else if (s.pend[PEND_P]) begin
            d.mode = ST_WARN;
            d.lamp = s.lamp | LAMP_PD6;
        end
        else if (s.pend[PEND_M]) begin
            d.mode = ST_MAINT;
            d.lamp = LAMP_PD6;
        end
        else begin
            d.mode = ST_NORMAL;
            d.lamp = s.phase ? PAT_B : PAT_A;
        end
        return d;
    endfunction

    state_t            s;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] count_inc;
    logic              done;
    logic [TICK_W-1:0] count_adv;

    always_comb
    begin
        s      = state;
        s.pend = state.pend | {item.maintenance_req, item.pedestrian_req, item.emergency_req};

        case (state.mode)
            ST_EMERG: limit = cfg.emergency_ticks;
            ST_WARN:  limit = cfg.warn_ticks;
            ST_WALK:  limit = cfg.walk_ticks;
            ST_MAINT: limit = cfg.blink_ticks;
            default:  limit = cfg.normal_phase_ticks;
        endcase

        count_inc = state.count + 1'b1;
        done      = item.tick && (count_inc >= limit);
        count_adv = done ? '0 : count_inc;

        state_next = s;
        case (state.mode)
            ST_EMERG:
            begin
                if (item.tick) begin
                    state_next.count = count_adv;
                    if (done) begin
                        s.pend[PEND_E] = 1'b0;
                        state_next     = dispatch(s);
                    end
                end
            end
            ST_WARN:
            begin
                if (s.pend[PEND_E]) begin
                    s.pend[PEND_P] = 1'b0;
                    state_next     = dispatch(s);
                end
                else if (item.tick) begin
                    state_next.count = count_adv;
                    if (done) begin
                        state_next.mode = ST_WALK;
                        state_next.lamp = PAT_A;
                    end
                end
            end
            ST_WALK:
            begin
                if (s.pend[PEND_E] || done) begin
                    s.pend[PEND_P] = 1'b0;
                    state_next     = dispatch(s);
                end
                else if (item.tick) begin
                    state_next.count = count_adv;
                end
            end
            ST_MAINT:
            begin
                if (s.pend[PEND_E] || s.pend[PEND_P]) begin
                    s.pend[PEND_M] = 1'b0;
                    state_next     = dispatch(s);
                end
                else if (item.tick) begin
                    state_next.count = count_adv;
                    if (done) begin
                        state_next.lamp = state.lamp ^ LAMP_PD6;
                    end
                end
            end
            default:
            begin
                if (s.pend != '0) begin
                    state_next = dispatch(s);
                end
                else begin
                    state_next.mode = ST_NORMAL;
                    if (item.tick) begin
                        state_next.count = count_adv;
                    end
                    state_next.phase = state.phase ^ done;
                    state_next.lamp  = (state.phase ^ done) ? PAT_B : PAT_A;
                end
            end
        endcase

        result.lamps = state_next.lamp;
        result.mode  = mode_code(state_next.mode);
    end

endmodule

// ----- sv/priority_traffic_light_controller_unit.sv -----
// ----------------------------------------------------------------------------
// priority_traffic_light_controller_unit: prioritized traffic light sequencer
// Latches emergency, pedestrian and maintenance requests, times each mode in
// ticks and returns the lamp pattern and mode after every transaction.
// ----------------------------------------------------------------------------
// One transaction is taken per clock while item_stall is low and gives
// exactly one result. All of the sequencer update (request latching, one
// 10-bit counter add and compare, priority dispatch) sits between the state
// register and the result register, so the sustained rate is one item per
// cycle without result stalls. A two-entry output buffer (output register
// plus skid register) decouples the sides: item_stall rises only once both
// entries hold results, i.e. once result_stall has held off a full
// output register while a transaction was being
// accepted. The user must write timing registers through
// cfg_we/cfg_index/cfg_data only while no result is outstanding; the block
// does not check it. Writes to indexes past the last register are ignored.
module priority_traffic_light_controller_unit
    import ptlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;

    result_t out_data_reg;
    logic    out_valid_reg;
    result_t skid_data_reg;
    logic    skid_valid_reg;

    logic    accept;
    logic    take;

    // Stall the input only when both buffer entries are occupied.
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Timing registers; unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.normal_phase_ticks <= RST_NORMAL_PHASE;
            cfg_reg.emergency_ticks    <= RST_EMERGENCY;
            cfg_reg.warn_ticks         <= RST_WARN;
            cfg_reg.walk_ticks         <= RST_WALK;
            cfg_reg.blink_ticks        <= RST_BLINK;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_NORMAL_PHASE: cfg_reg.normal_phase_ticks <= cfg_data;
                CFG_EMERGENCY:    cfg_reg.emergency_ticks    <= cfg_data;
                CFG_WARN:         cfg_reg.warn_ticks         <= cfg_data;
                CFG_WALK:         cfg_reg.walk_ticks         <= cfg_data;
                CFG_BLINK:        cfg_reg.blink_ticks        <= cfg_data;
                default:          ;
            endcase
        end
    end

    ptlc_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (item),
        .state_next (state_next),
        .result     (step_result)
    );

    // Advance the sequencer state once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.mode  <= ST_NORMAL;
            state_reg.phase <= 1'b0;
            state_reg.count <= '0;
            state_reg.pend  <= '0;
            state_reg.lamp  <= '0;
        end
        else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Output buffer control: the skid entry always drains into the output
    // register first, so result order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end
            else begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Buffer payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept) begin
            if (out_valid_reg && !take) begin
                skid_data_reg <= step_result;
            end
            else begin
                out_data_reg <= step_result;
            end
        end
    end

    // The skid entry is never occupied while the output register is empty.
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A transaction taken into an empty buffer is shown on the next clock.
    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("accepted transaction not presented");

    // A held skid entry keeps its data while the output stays stalled.
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost under stall");

    // Results only carry defined mode codes.
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.mode <= MODE_MAINT))
        else $error("result carries undefined mode code");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the priority traffic light controller
// Drives request/tick transactions through the valid/stall input channel,
// predicts lamps and mode for every accepted transaction with an in-bench
// model of the sequencer, and checks each result in order. A short directed
// table comes first, then several phases of random traffic under different
// timing register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptlc_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int TUNED_ROW   = 6;     // first table row run with short periods
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 85;
    localparam int LONG_HOLD   = 60;    // receiver hold-off in cycles
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 3;     // cycles after the last result

    // Index past the register map; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

    localparam logic [TICK_W-1:0] TICKS_MIN  = 10'd1;
    localparam logic [TICK_W-1:0] TICKS_MAX  = 10'd1023;
    localparam logic [TICK_W-1:0] TICKS_ZERO = 10'd0;

    // Request/tick codes in item_t bit order: emergency, pedestrian,
    // maintenance, tick
    localparam logic [3:0] NO_REQ  = 4'b0000;
    localparam logic [3:0] REQ_E   = 4'b1000;
    localparam logic [3:0] REQ_P   = 4'b0100;
    localparam logic [3:0] REQ_M   = 4'b0010;
    localparam logic [3:0] TICK_ON = 4'b0001;

    localparam logic [LAMP_W-1:0] LAMPS_ANY = '0;

    typedef struct packed {
        item_t   item;
        logic    fixed;     // 1: check against want, 0: check against predictor
        result_t want;
    } stim_row_t;

    // Directed table. Rows from TUNED_ROW on run with normal=1, emergency=2,
    // warn=1, walk=0 (zero period), blink=1.
    stim_row_t dir_rows [DIR_ROWS] = '{
        {NO_REQ,                         1'b1, PAT_A,     MODE_NORMAL}, // first step
        {TICK_ON,                        1'b1, PAT_A,     MODE_NORMAL},
        {REQ_E,                          1'b1, PAT_B,     MODE_EMERG},
        {REQ_E | TICK_ON,                1'b1, PAT_B,     MODE_EMERG},  // absorbed
        {REQ_P | TICK_ON,                1'b1, PAT_B,     MODE_EMERG},
        {REQ_M,                          1'b1, PAT_B,     MODE_EMERG},
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // emerg -> warn
        {NO_REQ,                         1'b0, LAMPS_ANY, MODE_NORMAL},
        {REQ_E,                          1'b0, LAMPS_ANY, MODE_NORMAL}, // abort warn
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL},
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // -> maint
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // blink
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL},
        {REQ_M | TICK_ON,                1'b0, LAMPS_ANY, MODE_NORMAL}, // absorbed
        {REQ_P,                          1'b0, LAMPS_ANY, MODE_NORMAL}, // leave maint
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // -> walk
        {NO_REQ,                         1'b0, LAMPS_ANY, MODE_NORMAL},
        {REQ_E | TICK_ON,                1'b0, LAMPS_ANY, MODE_NORMAL}, // abort walk
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL},
        {REQ_P | TICK_ON,                1'b0, LAMPS_ANY, MODE_NORMAL},
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL},
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // zero walk
        {TICK_ON,                        1'b0, LAMPS_ANY, MODE_NORMAL}, // phase flip
        {REQ_E | REQ_P | REQ_M | TICK_ON, 1'b0, LAMPS_ANY, MODE_NORMAL},
        {REQ_P | REQ_M,                  1'b0, LAMPS_ANY, MODE_NORMAL}
    };

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [TICK_W-1:0]      cfg_data     = '0;

    // Predicted sequencer state and its copy of the timing registers
    cfg_t              timing;
    logic [MODE_W-1:0] seq_mode;
    logic              seq_phase;
    logic [TICK_W-1:0] seq_count;
    logic [PEND_W-1:0] seq_pend;
    logic [LAMP_W-1:0] seq_lamp;

    result_t expected_lights [$];
    int      fail_count    = 0;
    bit      quiet         = 1'b0;  // no idling on either side
    bit      long_hold_req = 1'b0;

    priority_traffic_light_controller_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Serve the pending requests by priority; nothing pending shows the
    // normal pattern of the kept phase.
    task automatic serve_pending();
        seq_count = '0;
        if (seq_pend[PEND_E])
        begin
            seq_mode = MODE_EMERG;
            seq_lamp = PAT_B;
        end
        else if (seq_pend[PEND_P])
        begin
            seq_mode = MODE_WARN;
            seq_lamp = seq_lamp | LAMP_PD6;
        end
        else if (seq_pend[PEND_M])
        begin
            seq_mode = MODE_MAINT;
            seq_lamp = LAMP_PD6;
        end
        else
        begin
            seq_mode = MODE_NORMAL;
            seq_lamp = seq_phase ? PAT_B : PAT_A;
        end
    endtask

    // Advance the tick counter; a period of zero ends at the first tick.
    task automatic count_tick(input logic [TICK_W-1:0] period, output bit done);
        seq_count = seq_count + 1'b1;
        done = (seq_count >= period);
        if (done)
            seq_count = '0;
    endtask

    task automatic step_sequencer(input item_t it, output result_t r);
        bit done;
        done = 1'b0;
        // Latch request edges before any mode logic
        if (it.emergency_req)
            seq_pend[PEND_E] = 1'b1;
        if (it.pedestrian_req)
            seq_pend[PEND_P] = 1'b1;
        if (it.maintenance_req)
            seq_pend[PEND_M] = 1'b1;
        case (seq_mode)
            MODE_EMERG:
            begin
                if (it.tick)
                    count_tick(timing.emergency_ticks, done);
                if (done)
                begin
                    seq_pend[PEND_E] = 1'b0;
                    serve_pending();
                end
            end
            MODE_WARN:
            begin
                if (seq_pend[PEND_E])
                begin
                    seq_pend[PEND_P] = 1'b0;
                    serve_pending();
                end
                else
                begin
                    if (it.tick)
                        count_tick(timing.warn_ticks, done);
                    if (done)
                    begin
                        seq_mode = MODE_WALK;
                        seq_lamp = PAT_A;
                    end
                end
            end
            MODE_WALK:
            begin
                if (!seq_pend[PEND_E] && it.tick)
                    count_tick(timing.walk_ticks, done);
                if (seq_pend[PEND_E] || done)
                begin
                    seq_pend[PEND_P] = 1'b0;
                    serve_pending();
                end
            end
            MODE_MAINT:
            begin
                if (seq_pend[PEND_E] || seq_pend[PEND_P])
                begin
                    seq_pend[PEND_M] = 1'b0;
                    serve_pending();
                end
                else
                begin
                    if (it.tick)
                        count_tick(timing.blink_ticks, done);
                    if (done)
                        seq_lamp = seq_lamp ^ LAMP_PD6;
                end
            end
            default:
            begin
                // Any pending request is served at once; the tick is dropped
                if (seq_pend != '0)
                    serve_pending();
                else
                begin
                    seq_mode = MODE_NORMAL;
                    if (it.tick)
                        count_tick(timing.normal_phase_ticks, done);
                    if (done)
                        seq_phase = ~seq_phase;
                    seq_lamp = seq_phase ? PAT_B : PAT_A;
                end
            end
        endcase
        r.lamps = seq_lamp;
        r.mode  = seq_mode;
    endtask

    // Hold cfg_we high across a batch; the caller drops it afterwards.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_NORMAL_PHASE: timing.normal_phase_ticks = val;
            CFG_EMERGENCY:    timing.emergency_ticks    = val;
            CFG_WARN:         timing.warn_ticks         = val;
            CFG_WALK:         timing.walk_ticks         = val;
            CFG_BLINK:        timing.blink_ticks        = val;
            default:          ;
        endcase
    endtask

    task automatic program_timing(input cfg_t c);
        write_reg(CFG_NORMAL_PHASE, c.normal_phase_ticks);
        write_reg(CFG_EMERGENCY, c.emergency_ticks);
        write_reg(CFG_WARN, c.warn_ticks);
        write_reg(CFG_WALK, c.walk_ticks);
        write_reg(CFG_BLINK, c.blink_ticks);
        // Unmapped index with random data: must leave every register alone
        write_reg(CFG_SPARE, TICK_W'($urandom_range(0, 1023)));
        cfg_we <= 1'b0;
    endtask

    // Offer one transaction, wait for it to be taken, record the expected
    // result, then maybe idle for a burst.
    task automatic send_item(input item_t it, input bit fixed, input result_t want);
        result_t predicted;
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        step_sequencer(it, predicted);
        expected_lights.push_back(fixed ? want : predicted);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (expected_lights.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    // Mostly sparse requests with steady ticks so that modes run to their
    // end; one transaction in ten is plain noise.
    function automatic item_t random_item();
        item_t it;
        if ($urandom_range(0, 9) == 0)
            it = item_t'(4'($urandom_range(0, 15)));
        else
        begin
            it.emergency_req   = ($urandom_range(0, 23) == 0);
            it.pedestrian_req  = ($urandom_range(0, 9) == 0);
            it.maintenance_req = ($urandom_range(0, 9) == 0);
            it.tick            = ($urandom_range(0, 3) != 0);
        end
        return it;
    endfunction

    // Result side: check every accepted result against the oldest
    // expectation and stall in random bursts, or for a long hold on request.
    initial
    begin : result_sink
        int      hold_left;
        result_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (expected_lights.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: lamps=%h mode=%0d",
                                 result.lamps, result.mode);
                end
                else
                begin
                    want = expected_lights.pop_front();
                    if (result.lamps !== want.lamps || result.mode !== want.mode)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at %0t: lamps exp=%h got=%h, mode exp=%0d got=%0d",
                                     $realtime, want.lamps, result.lamps,
                                     want.mode, result.mode);
                    end
                end
            end
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 11);
            result_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    initial
    begin : stimulus
        cfg_t c;
        timing    = {RST_NORMAL_PHASE, RST_EMERGENCY, RST_WARN, RST_WALK, RST_BLINK};
        seq_mode  = MODE_NORMAL;
        seq_phase = 1'b0;
        seq_count = '0;
        seq_pend  = '0;
        seq_lamp  = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset timing first, then short periods
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (r == TUNED_ROW)
            begin
                drain();
                c = {TICKS_MIN, 10'd2, TICKS_MIN, TICKS_ZERO, TICKS_MIN};
                program_timing(c);
            end
            send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);
        end
        drain();

        // Random phases, each with its own timing setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: c = {TICKS_MIN, TICKS_MIN, TICKS_MIN, TICKS_MIN, TICKS_MIN};
                1: c = {TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX};
                3:
                begin
                    c.normal_phase_ticks = TICK_W'($urandom_range(0, 1023));
                    c.emergency_ticks    = TICK_W'($urandom_range(0, 1023));
                    c.warn_ticks         = TICK_W'($urandom_range(0, 1023));
                    c.walk_ticks         = TICK_W'($urandom_range(0, 1023));
                    c.blink_ticks        = TICK_W'($urandom_range(0, 1023));
                end
                default:
                begin
                    c.normal_phase_ticks = TICK_W'($urandom_range(1, 6));
                    c.emergency_ticks    = TICK_W'($urandom_range(1, 6));
                    c.warn_ticks         = TICK_W'($urandom_range(1, 6));
                    c.walk_ticks         = TICK_W'($urandom_range(1, 6));
                    c.blink_ticks        = TICK_W'($urandom_range(1, 6));
                end
            endcase
            program_timing(c);
            // Last phase runs at full rate with no idling
            quiet = (ph == PHASES - 1);
            // Hold the receiver off long enough to back up the input channel
            if (ph == 3)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Pause the sender mid-phase until the pipe is empty
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    drain();
                send_item(random_item(), 1'b0, '0);
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
